// File: design/mms_pkg.sv
// mms_pkg: shared types, codes and constants of the motor move supervisor
// no dependencies; used by mms_step and motor_move_supervisor_core

package mms_pkg;

    localparam int unsigned DataW   = 16;
    localparam int unsigned MarginW = 4;
    localparam int unsigned DirW    = 2;
    localparam int unsigned SpeedW  = 8;
    localparam int unsigned StatusW = 3;
    localparam int unsigned CfgIdxW = 3;

    // operation codes of an input transaction
    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    // drive direction codes
    localparam logic [DirW-1:0] DIR_FWD  = 2'd1;
    localparam logic [DirW-1:0] DIR_REV  = 2'd2;
    localparam logic [DirW-1:0] DIR_STOP = 2'd3;

    localparam logic [SpeedW-1:0] RUN_DUTY  = 8'd255;
    localparam logic [SpeedW-1:0] STOP_DUTY = 8'd0;

    typedef enum logic [StatusW-1:0] {
        ST_IDLE     = 3'd0,
        ST_RUN      = 3'd1,
        ST_ARRIVED  = 3'd2,
        ST_OC_FAULT = 3'd3,
        ST_TO_FAULT = 3'd4
    } t_status;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_APPROACH_WINDOW   = 3'd0,
        CFG_OVERCURRENT_LIMIT = 3'd1,
        CFG_OVERCURRENT_TICKS = 3'd2,
        CFG_TIMEOUT_TICKS     = 3'd3,
        CFG_INITIAL_MARGIN    = 3'd4
    } t_cfg_idx;

    // configuration reset values
    localparam logic [DataW-1:0]   RST_APPROACH_WINDOW   = 16'd20;
    localparam logic [DataW-1:0]   RST_OVERCURRENT_LIMIT = 16'd51000;
    localparam logic [DataW-1:0]   RST_OVERCURRENT_TICKS = 16'd12000;
    localparam logic [DataW-1:0]   RST_TIMEOUT_TICKS     = 16'd20000;
    localparam logic [MarginW-1:0] RST_INITIAL_MARGIN    = 4'd10;

    // braking margin table: current above THR[i] gives margin i
    localparam int unsigned NumThr = 10;
    localparam logic [DataW-1:0] THR [NumThr] = '{
        16'd55000, 16'd50000, 16'd45000, 16'd40000, 16'd35000,
        16'd30000, 16'd25000, 16'd20000, 16'd15000, 16'd10000
    };
    localparam logic [DataW-1:0]   THR_LOW      = 16'd8500;
    localparam logic [MarginW-1:0] MARGIN_LOW   = 4'd10;
    localparam logic [MarginW-1:0] MARGIN_QUIET = 4'd15;

    typedef struct packed {
        logic [DataW-1:0]   approach_window;
        logic [DataW-1:0]   overcurrent_limit;
        logic [DataW-1:0]   overcurrent_ticks;
        logic [DataW-1:0]   timeout_ticks;
        logic [MarginW-1:0] initial_margin;
    } t_cfg;

    typedef struct packed {
        t_op              op;
        logic [DataW-1:0] target_pulses;
        logic [DirW-1:0]  direction;
        logic [DataW-1:0] encoder_count;
        logic [DataW-1:0] motor_current;
    } t_item;

    typedef struct packed {
        logic               moving;
        logic [DataW-1:0]   target;
        logic [DirW-1:0]    dir;
        logic [MarginW-1:0] margin;
        logic [DataW-1:0]   oc_cnt;
        logic [DataW-1:0]   tick_cnt;
    } t_state;

    typedef struct packed {
        logic [DirW-1:0]   motor_dir;
        logic [SpeedW-1:0] motor_speed;
        logic              clear_encoder;
        t_status           status;
    } t_result;

    // braking margin from a current sample; highest exceeded threshold wins
    function automatic logic [MarginW-1:0] margin_for(input logic [DataW-1:0] cur);
        logic [MarginW-1:0] m;
        m = MARGIN_QUIET;
        if (cur > THR_LOW) begin
            m = MARGIN_LOW;
        end
        for (int i = NumThr - 1; i >= 0; i--) begin
            if (cur > THR[i]) begin
                m = MarginW'(i);
            end
        end
        return m;
    endfunction

endpackage

// File: design/mms_step.sv
// mms_step: one supervision step, next state and result from the current state
// depends on mms_pkg

module mms_step (
    input  mms_pkg::t_cfg    i_cfg,
    input  mms_pkg::t_state  i_state,
    input  mms_pkg::t_item   i_item,
    output mms_pkg::t_state  o_state,
    output mms_pkg::t_result o_result
);

    logic [mms_pkg::DataW-1:0]   remaining;
    logic [mms_pkg::MarginW-1:0] margin_new;
    logic                        oc_over;
    logic                        oc_fault;
    logic                        to_fault;
    logic                        arrived;
    logic                        drivable;

    // remaining distance clamped at zero
    assign remaining = (i_state.target > i_item.encoder_count) ?
                       (i_state.target - i_item.encoder_count) : '0;

    assign margin_new = (remaining < i_cfg.approach_window) ?
                        mms_pkg::margin_for(i_item.motor_current) : i_state.margin;

    assign oc_over  = i_item.motor_current > i_cfg.overcurrent_limit;
    assign oc_fault = oc_over && !(i_state.oc_cnt < i_cfg.overcurrent_ticks);
    assign to_fault = !(i_state.tick_cnt < i_cfg.timeout_ticks);
    assign arrived  = remaining <= {{(mms_pkg::DataW-mms_pkg::MarginW){1'b0}}, margin_new};
    assign drivable = (i_state.dir == mms_pkg::DIR_FWD) || (i_state.dir == mms_pkg::DIR_REV);

    always_comb begin
        o_state                = i_state;
        o_result.motor_dir     = mms_pkg::DIR_STOP;
        o_result.motor_speed   = mms_pkg::STOP_DUTY;
        o_result.clear_encoder = 1'b0;
        o_result.status        = mms_pkg::ST_IDLE;
        priority if (i_item.op == mms_pkg::OP_START) begin
            o_state.moving         = 1'b1;
            o_state.target         = i_item.target_pulses;
            o_state.dir            = i_item.direction;
            o_state.margin         = i_cfg.initial_margin;
            o_state.oc_cnt         = '0;
            o_state.tick_cnt       = '0;
            o_result.clear_encoder = 1'b1;
            o_result.status        = mms_pkg::ST_RUN;
        end else if (!i_state.moving) begin
            o_result.status = mms_pkg::ST_IDLE;
        end else begin
            o_state.margin = margin_new;
            priority if (oc_fault) begin
                o_state.moving  = 1'b0;
                o_result.status = mms_pkg::ST_OC_FAULT;
            end else begin
                o_state.oc_cnt = oc_over ? i_state.oc_cnt + 1'b1 : '0;
                priority if (to_fault) begin
                    o_state.tick_cnt = '0;
                    o_state.moving   = 1'b0;
                    o_result.status  = mms_pkg::ST_TO_FAULT;
                end else begin
                    o_state.tick_cnt = i_state.tick_cnt + 1'b1;
                    if (arrived) begin
                        o_state.moving  = 1'b0;
                        o_result.status = mms_pkg::ST_ARRIVED;
                    end else begin
                        o_result.status = mms_pkg::ST_RUN;
                        if (drivable) begin
                            o_result.motor_dir   = i_state.dir;
                            o_result.motor_speed = mms_pkg::RUN_DUTY;
                        end
                    end
                end
            end
        end
    end

endmodule

// File: design/motor_move_supervisor_core.sv
// motor_move_supervisor_core: top level of the motor move supervisor
// depends on mms_pkg and mms_step
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+---------------------------------------
//  input     | in        | i_in_valid / o_in_ready   | op, target_pulses, direction,
//            |           |                           | encoder_count, motor_current
//  result    | out       | o_out_valid / i_out_ready | motor_dir, motor_speed, clear_encoder,
//            |           |                           | status
//  config    | in        | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_wdata
//
// one transaction per cycle sustained while results are taken; a taken input transaction passes
// the input register, then the step logic into the result register
// the move state is updated at the same edge that loads the result register
// reset is synchronous, active low; clears move state, config and both valid bits
// a stalled result holds the result register; the input register still takes
// one more transaction, and input ready drops only when both stages are full

module motor_move_supervisor_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [mms_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [mms_pkg::DataW-1:0]         i_cfg_wdata,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_op,
    input  logic [mms_pkg::DataW-1:0]         i_target_pulses,
    input  logic [mms_pkg::DirW-1:0]          i_direction,
    input  logic [mms_pkg::DataW-1:0]         i_encoder_count,
    input  logic [mms_pkg::DataW-1:0]         i_motor_current,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [mms_pkg::DirW-1:0]          o_motor_dir,
    output logic [mms_pkg::SpeedW-1:0]        o_motor_speed,
    output logic                              o_clear_encoder,
    output logic [mms_pkg::StatusW-1:0]       o_status
);

    // configuration registers
    mms_pkg::t_cfg    r_cfg;

    // input register stage
    mms_pkg::t_item   r_in;
    logic             r_in_vld;

    // move state
    mms_pkg::t_state  r_st;
    mms_pkg::t_state  n_st;

    // result register stage
    mms_pkg::t_result r_res;
    mms_pkg::t_result n_res;
    logic             r_out_vld;

    logic             adv;       // input register moves into the result register
    logic             in_take;   // input transaction accepted

    // the input stage drains whenever the result register is empty or being taken
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;
    assign in_take    = i_in_valid && o_in_ready;

    // configuration writes, indexes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.approach_window   <= mms_pkg::RST_APPROACH_WINDOW;
            r_cfg.overcurrent_limit <= mms_pkg::RST_OVERCURRENT_LIMIT;
            r_cfg.overcurrent_ticks <= mms_pkg::RST_OVERCURRENT_TICKS;
            r_cfg.timeout_ticks     <= mms_pkg::RST_TIMEOUT_TICKS;
            r_cfg.initial_margin    <= mms_pkg::RST_INITIAL_MARGIN;
        end else if (i_cfg_we) begin
            unique case (mms_pkg::t_cfg_idx'(i_cfg_idx))
                mms_pkg::CFG_APPROACH_WINDOW:   r_cfg.approach_window   <= i_cfg_wdata;
                mms_pkg::CFG_OVERCURRENT_LIMIT: r_cfg.overcurrent_limit <= i_cfg_wdata;
                mms_pkg::CFG_OVERCURRENT_TICKS: r_cfg.overcurrent_ticks <= i_cfg_wdata;
                mms_pkg::CFG_TIMEOUT_TICKS:     r_cfg.timeout_ticks     <= i_cfg_wdata;
                mms_pkg::CFG_INITIAL_MARGIN: begin
                    r_cfg.initial_margin <= i_cfg_wdata[mms_pkg::MarginW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register: payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.op            <= mms_pkg::t_op'(i_op);
            r_in.target_pulses <= i_target_pulses;
            r_in.direction     <= i_direction;
            r_in.encoder_count <= i_encoder_count;
            r_in.motor_current <= i_motor_current;
        end
    end

    // supervision step between the input register and the result register
    mms_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_st),
        .i_item   (r_in),
        .o_state  (n_st),
        .o_result (n_res)
    );

    // move state advances with each transaction passing the step logic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.moving   <= 1'b0;
            r_st.target   <= '0;
            r_st.dir      <= mms_pkg::DIR_STOP;
            r_st.margin   <= mms_pkg::RST_INITIAL_MARGIN;
            r_st.oc_cnt   <= '0;
            r_st.tick_cnt <= '0;
        end else if (adv) begin
            r_st <= n_st;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_motor_dir     = r_res.motor_dir;
    assign o_motor_speed   = r_res.motor_speed;
    assign o_clear_encoder = r_res.clear_encoder;
    assign o_status        = r_res.status;

`ifndef ASSERT_OFF
    // a start transaction always leaves the block moving
    a_start_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && (r_in.op == mms_pkg::OP_START) |=> r_st.moving)
        else $error("start transaction did not arm the move");

    // a tick while idle leaves the move state untouched
    a_idle_tick_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && (r_in.op == mms_pkg::OP_TICK) && !r_st.moving |=> $stable(r_st))
        else $error("idle tick changed the move state");

    // encoder clear only comes with the running status of a start
    a_clear_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clear_encoder |->
            (o_status == mms_pkg::ST_RUN) && (o_motor_dir == mms_pkg::DIR_STOP))
        else $error("encoder clear outside a start result");

    // drive duty only while running in a real direction
    a_drive_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_motor_speed != mms_pkg::STOP_DUTY) |->
            (o_status == mms_pkg::ST_RUN) &&
            ((o_motor_dir == mms_pkg::DIR_FWD) || (o_motor_dir == mms_pkg::DIR_REV)))
        else $error("motor driven outside a running result");
`endif

endmodule
